// ===== hdl/iate_pkg.sv =====
// ----------------------------------------------------------------------------
// iate_pkg: shared types and constants of the indexed array table engine
// Operation and status codes, cell control and search carry structs.
// ----------------------------------------------------------------------------
package iate_pkg;

	localparam int DEPTH = 64;
	localparam int POS_W = 7;
	localparam int DATA_W = 32;
	localparam int FPOS_W = 6;
	localparam int ECNT_W = 7;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_GET    = 3'd4,
		OP_SET    = 3'd5,
		OP_FIND   = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		CK_NONE,
		CK_WRITE,
		CK_INSERT,
		CK_REMOVE
	} cell_kind_t;

	// broadcast control seen by every cell
	typedef struct packed {
		cell_kind_t               kind;
		logic [CMP_W-1:0]         pos;
		logic [CMP_W-1:0]         count;
		logic signed [DATA_W-1:0] val;
		logic                     by_value;
		logic [IDX_W-1:0]         sel;
	} cell_ctl_t;

	// search result handed from cell to cell toward index zero
	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         idx;
	} carry_t;

endpackage

// ===== hdl/iate_if.sv =====
// ----------------------------------------------------------------------------
// iate request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface iate_req_if;
	import iate_pkg::*;
	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] data_in;

	modport source (output valid, output op, output position, output data_in, input ready);
	modport sink (input valid, input op, input position, input data_in, output ready);
endinterface

interface iate_rsp_if;
	import iate_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic                     found;
	logic [FPOS_W-1:0]        found_position;
	status_t                  status;
	logic [ECNT_W-1:0]        element_count;

	modport source (output valid, output data_out, output found, output found_position,
		output status, output element_count, input ready);
	modport sink (input valid, input data_out, input found, input found_position,
		input status, input element_count, output ready);
endinterface

// ===== hdl/indexed_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_array_table_engine: packed array of signed words with list ops
// Push, pop, insert, remove, get, set, find and clear on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (op, position, data_in); it is taken when valid
//   and ready are both high. rsp returns exactly one response per request
//   with data_out, found, found_position, status and element_count.
//   Ready is high only while no request is in progress; one request is
//   worked on at a time.
// Sequence:
//   every request passes through the execute and done states to the output
//   register; unflagged pop, get and find also pass a sweep state, since the
//   search carry walks the cell chain one cell per cycle down to cell zero.
//   A new request is taken once the previous one has left the done state.
// Reset:
//   arst_n clears the state, the count and the output valid flag; stored
//   words are kept undefined and are never read before they are written.
// Stall:
//   a finished response waits in the output register; the engine holds the
//   next request's result until the output is free, and takes new requests
//   while the response waits.
// ----------------------------------------------------------------------------
module indexed_array_table_engine (
	input  logic   clk,
	input  logic   arst_n,
	iate_req_if.sink   req,
	iate_rsp_if.source rsp
);
	import iate_pkg::*;

	state_t                   state_q;
	state_t                   state_d;
	op_t                      op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]         sel_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         sweep_q;
	status_t                  status_q;
	status_t                  status_d;
	logic                     need_sweep;
	logic                     out_load;
	cell_ctl_t                ctl;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic                     out_found_q;
	logic [FPOS_W-1:0]        out_fpos_q;
	status_t                  out_status_q;
	logic [ECNT_W-1:0]        out_count_q;

	logic signed [DATA_W-1:0] elem [DEPTH];
	carry_t                   carry [DEPTH+1];

	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	assign pos_w = CMP_W'(pos_q);
	assign cnt_w = CMP_W'(count_q);

	// classify the held request against the current count
	always_comb begin
		status_d = ST_OK;
		case (op_q)
			OP_PUSH: if (count_q == CNT_W'(DEPTH)) status_d = ST_FULL;
			OP_POP: if (count_q == '0) status_d = ST_EMPTY;
			OP_INSERT: begin
				if (pos_w > cnt_w) status_d = ST_RANGE;
				else if (count_q == CNT_W'(DEPTH)) status_d = ST_FULL;
			end
			OP_REMOVE, OP_GET, OP_SET: if (pos_w >= cnt_w) status_d = ST_RANGE;
			default: status_d = ST_OK;
		endcase
	end

	assign need_sweep = (status_d == ST_OK) &&
		(op_q == OP_POP || op_q == OP_GET || op_q == OP_FIND);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_EXEC;
			S_EXEC: state_d = need_sweep ? S_SWEEP : S_DONE;
			S_SWEEP: if (sweep_q == '0) state_d = S_DONE;
			S_DONE: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshake and broadcast cell control
	always_comb begin
		req.ready    = 1'b0;
		out_load     = 1'b0;
		ctl.kind     = CK_NONE;
		ctl.pos      = pos_w;
		ctl.count    = cnt_w;
		ctl.val      = val_q;
		ctl.by_value = (op_q == OP_FIND);
		ctl.sel      = sel_q;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_EXEC: begin
				if (status_d == ST_OK) begin
					case (op_q)
						OP_PUSH: begin
							ctl.kind = CK_INSERT;
							ctl.pos  = cnt_w;
						end
						OP_INSERT: ctl.kind = CK_INSERT;
						OP_REMOVE: ctl.kind = CK_REMOVE;
						OP_SET: ctl.kind = CK_WRITE;
						default: ctl.kind = CK_NONE;
					endcase
				end
			end
			S_SWEEP: ctl.kind = CK_NONE;
			S_DONE: out_load = !out_valid_q || rsp.ready;
			default: req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// commit count changes once the request is classified
			if (state_q == S_EXEC && status_d == ST_OK) begin
				case (op_q)
					OP_PUSH, OP_INSERT: count_q <= count_q + CNT_W'(1);
					OP_POP, OP_REMOVE: count_q <= count_q - CNT_W'(1);
					OP_CLEAR: count_q <= '0;
					default: count_q <= count_q;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request, search and response payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.op;
			pos_q <= req.position;
			val_q <= req.data_in;
			// pop reads the top word, get reads at the position
			if (req.op == OP_POP) sel_q <= IDX_W'(count_q - CNT_W'(1));
			else sel_q <= IDX_W'(req.position);
		end
		if (state_q == S_EXEC) begin
			status_q <= status_d;
			sweep_q  <= IDX_W'(DEPTH - 1);
		end else if (state_q == S_SWEEP) begin
			sweep_q <= sweep_q - IDX_W'(1);
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_count_q  <= ECNT_W'(count_q);
			if (status_q == ST_OK && (op_q == OP_POP || op_q == OP_GET))
				out_data_q <= carry[0].data;
			else
				out_data_q <= '0;
			if (op_q == OP_FIND && carry[0].hit) begin
				out_found_q <= 1'b1;
				out_fpos_q  <= FPOS_W'(carry[0].idx);
			end else begin
				out_found_q <= 1'b0;
				out_fpos_q  <= '0;
			end
		end
	end

	// chain of cells: carry enters empty above the top cell
	assign carry[DEPTH] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;
		if (g == 0) begin : g_lo
			assign lower = '0;
		end else begin : g_lo
			assign lower = elem[g-1];
		end
		if (g == DEPTH - 1) begin : g_hi
			assign upper = '0;
		end else begin : g_hi
			assign upper = elem[g+1];
		end
		iate_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(g)),
			.ctl        (ctl),
			.lower_elem (lower),
			.upper_elem (upper),
			.carry_in   (carry[g+1]),
			.elem       (elem[g]),
			.carry_out  (carry[g])
		);
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.data_out       = out_data_q;
	assign rsp.found          = out_found_q;
	assign rsp.found_position = out_fpos_q;
	assign rsp.status         = out_status_q;
	assign rsp.element_count  = out_count_q;

	// count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above capacity");

	// an accepted request is classified in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

	// a flagged request leaves the count unchanged
	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && status_d != ST_OK) |=> (count_q == $past(count_q)))
		else $error("flagged request changed the count");

	// the sweep ends after its last cell step
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && sweep_q == '0) |=> (state_q == S_DONE))
		else $error("search sweep did not finish");

endmodule

// ===== hdl/iate_cell.sv =====
// ----------------------------------------------------------------------------
// iate_cell: one element slot of the array chain
// Holds one word, shifts with its neighbors and forwards the search carry.
// ----------------------------------------------------------------------------
module iate_cell (
	input  logic                              clk,
	input  logic [iate_pkg::IDX_W-1:0]        idx,
	input  iate_pkg::cell_ctl_t               ctl,
	input  logic signed [iate_pkg::DATA_W-1:0] lower_elem,
	input  logic signed [iate_pkg::DATA_W-1:0] upper_elem,
	input  iate_pkg::carry_t                  carry_in,
	output logic signed [iate_pkg::DATA_W-1:0] elem,
	output iate_pkg::carry_t                  carry_out
);
	import iate_pkg::*;

	logic signed [DATA_W-1:0] elem_q;
	logic signed [DATA_W-1:0] elem_d;
	carry_t                   carry_q;
	carry_t                   carry_d;
	logic [CMP_W-1:0]         idx_w;
	logic                     local_hit;

	assign idx_w = CMP_W'(idx);

	always_comb begin
		elem_d = elem_q;
		case (ctl.kind)
			CK_WRITE: begin
				if (idx_w == ctl.pos) elem_d = ctl.val;
			end
			CK_INSERT: begin
				if (idx_w == ctl.pos) elem_d = ctl.val;
				else if (idx_w > ctl.pos && idx_w <= ctl.count) elem_d = lower_elem;
			end
			CK_REMOVE: begin
				if (idx_w >= ctl.pos && (idx_w + CMP_W'(1)) < ctl.count) elem_d = upper_elem;
			end
			default: elem_d = elem_q;
		endcase
	end

	// lowest hit wins: a local hit overrides whatever arrives from above
	always_comb begin
		if (ctl.by_value) local_hit = (idx_w < ctl.count) && (elem_q == ctl.val);
		else local_hit = (idx == ctl.sel);
		if (local_hit) begin
			carry_d.hit  = 1'b1;
			carry_d.data = elem_q;
			carry_d.idx  = idx;
		end else begin
			carry_d = carry_in;
		end
	end

	always_ff @(posedge clk) begin
		elem_q  <= elem_d;
		carry_q <= carry_d;
	end

	assign elem      = elem_q;
	assign carry_out = carry_q;

endmodule

// ===== dv/indexed_array_table_engine_checker.sv =====
// ----------------------------------------------------------------------------
// indexed_array_table_engine_checker: response predictor and comparator
// Watches both channels. It keeps a shadow copy of the word array and the
// element count, and it predicts one response for every accepted request.
// Each accepted response is compared field by field with the oldest response
// still waiting.
// ----------------------------------------------------------------------------
module indexed_array_table_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	iate_req_if         req,
	iate_rsp_if         rsp,
	output int unsigned mismatch_count,
	output int unsigned open_count
);
	import iate_pkg::*;

	typedef struct {
		op_t                      op;
		logic signed [DATA_W-1:0] data_out;
		logic                     found;
		logic [FPOS_W-1:0]        found_position;
		status_t                  status;
		logic [ECNT_W-1:0]        element_count;
	} list_result_t;

	logic signed [DATA_W-1:0] shadow_words [DEPTH];
	int                       shadow_count = 0;
	list_result_t             awaited_results [$];
	int unsigned              bad_results = 0;

	// Apply one request to the shadow array; return the response it must give.
	function automatic list_result_t apply_list_op(op_t op, int pos,
			logic signed [DATA_W-1:0] word);
		list_result_t res;
		int i;
		res.op = op;
		res.data_out = '0;
		res.found = 1'b0;
		res.found_position = '0;
		res.status = ST_OK;
		case (op)
		OP_PUSH: begin
			if (shadow_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				shadow_words[shadow_count] = word;
				shadow_count++;
			end
		end
		OP_POP: begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				shadow_count--;
				res.data_out = shadow_words[shadow_count];
			end
		end
		OP_INSERT: begin
			// range is judged before fullness
			if (pos > shadow_count) begin
				res.status = ST_RANGE;
			end else if (shadow_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				for (i = shadow_count; i > pos; i--)
					shadow_words[i] = shadow_words[i - 1];
				shadow_words[pos] = word;
				shadow_count++;
			end
		end
		OP_REMOVE: begin
			if (pos >= shadow_count) begin
				res.status = ST_RANGE;
			end else begin
				for (i = pos; i + 1 < shadow_count; i++)
					shadow_words[i] = shadow_words[i + 1];
				shadow_count--;
			end
		end
		OP_GET: begin
			if (pos >= shadow_count)
				res.status = ST_RANGE;
			else
				res.data_out = shadow_words[pos];
		end
		OP_SET: begin
			if (pos >= shadow_count)
				res.status = ST_RANGE;
			else
				shadow_words[pos] = word;
		end
		OP_FIND: begin
			for (i = 0; i < shadow_count && !res.found; i++) begin
				if (shadow_words[i] == word) begin
					res.found = 1'b1;
					res.found_position = i[FPOS_W-1:0];
				end
			end
		end
		OP_CLEAR: begin
			shadow_count = 0;
		end
		endcase
		res.element_count = shadow_count[ECNT_W-1:0];
		return res;
	endfunction

	task automatic note_failure(string what);
		bad_results++;
		if (bad_results <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			shadow_count = 0;
			bad_results = 0;
			mismatch_count <= 0;
			open_count <= 0;
		end else begin
			// responses first: a request taken at this edge cannot answer yet
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					note_failure($sformatf(
						"unexpected response: data_out %0d found %0b pos %0d status %0d count %0d",
						rsp.data_out, rsp.found, rsp.found_position, rsp.status,
						rsp.element_count));
				end else begin
					want = awaited_results.pop_front();
					if (rsp.data_out !== want.data_out || rsp.found !== want.found ||
							rsp.found_position !== want.found_position ||
							rsp.status !== want.status ||
							rsp.element_count !== want.element_count)
						note_failure($sformatf({"mismatch on %s: expected data_out %0d ",
							"found %0b pos %0d status %0d count %0d, got data_out %0d ",
							"found %0b pos %0d status %0d count %0d"}, want.op.name(),
							want.data_out, want.found, want.found_position, want.status,
							want.element_count, rsp.data_out, rsp.found,
							rsp.found_position, rsp.status, rsp.element_count));
				end
			end
			if (req.valid && req.ready)
				awaited_results.push_back(apply_list_op(req.op, int'(req.position),
					req.data_in));
			mismatch_count <= bad_results;
			open_count <= awaited_results.size();
		end
	end

endmodule

// ===== dv/indexed_array_table_engine_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_array_table_engine_tb: stimulus and verdict for the array engine
// A directed pass covers empty, full and range cases for every operation. A
// full-array fill follows. After that come phases of random requests, which
// lean toward growing, toward shrinking or toward a balanced mix, with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module indexed_array_table_engine_tb;
	import iate_pkg::*;

	// cycles with no handshake on either channel before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 14;
	localparam int PHASE_LEN = 62;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] WORD_ONES = 32'shFFFF_FFFF;
	localparam logic [POS_W-1:0] POS_TOP = '1;

	typedef enum logic [1:0] {
		MIX_GROW,
		MIX_SHRINK,
		MIX_BALANCED
	} phase_mix_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        steady_flow;
	int unsigned mismatch_count;
	int unsigned open_count;
	int unsigned idle_cycles;

	// a small pool of words, so finds hit and repeated values show up
	logic signed [DATA_W-1:0] value_pool [8];

	// op weights in percent, in op code order: push pop insert remove get set find clear
	int op_weight [3][8] = '{
		'{40,  4, 25,  4,  8,  8, 10, 1},
		'{ 5, 30,  4, 30, 10,  5, 15, 1},
		'{14, 14, 14, 14, 14, 12, 14, 4}
	};

	iate_req_if req_if ();
	iate_rsp_if rsp_if ();

	indexed_array_table_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	indexed_array_table_engine_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.mismatch_count (mismatch_count),
		.open_count     (open_count)
	);

	always #1 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow)
			return 0;
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic op_t pick_op(phase_mix_t mix);
		int r;
		int acc;
		r = $urandom_range(0, 99);
		acc = 0;
		for (int k = 0; k < 8; k++) begin
			acc += op_weight[int'(mix)][k];
			if (r < acc)
				return op_t'(k);
		end
		return OP_CLEAR;
	endfunction

	// Bias toward both ends of the array; a few positions lie past any count.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return POS_W'($urandom_range(0, 7));
		if (r < 60)
			return POS_W'($urandom_range(DEPTH - 8, DEPTH));
		if (r < 90)
			return POS_W'($urandom_range(0, DEPTH));
		return POS_W'($urandom_range(DEPTH + 1, (1 << POS_W) - 1));
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		// refresh one pool slot now and then
		if ($urandom_range(0, 9) == 0)
			value_pool[$urandom_range(0, 7)] = $urandom();
		if (r < 55)
			return value_pool[$urandom_range(0, 7)];
		if (r < 90)
			return $urandom();
		case ($urandom_range(0, 3))
		0: return WORD_MIN;
		1: return WORD_MAX;
		2: return WORD_ONES;
		default: return '0;
		endcase
	endfunction

	// Offer one request and hold it until the engine takes it.
	task automatic issue(input op_t op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.position <= pos;
		req_if.data_in <= word;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every response is back.
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
	endtask

	// Hang detection: count cycles in which neither channel moves.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_if.valid && req_if.ready) ||
				(rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Response side: stall at random, except during steady stretches.
	initial begin : response_sink
		int hold;
		rsp_if.ready <= 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				rsp_if.ready <= 1'b0;
				hold--;
			end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
				rsp_if.ready <= 1'b0;
				hold = pick_gap();
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin : request_source
		phase_mix_t mix;
		arst_n <= 1'b0;
		steady_flow <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.op <= OP_PUSH;
		req_if.position <= '0;
		req_if.data_in <= '0;
		value_pool = '{WORD_MIN, WORD_MAX, WORD_ONES, '0, $urandom(), $urandom(),
			$urandom(), $urandom()};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Run find, pop, get, remove, set and insert against the empty array: all fail except find.
		issue(OP_FIND, '0, '0);
		issue(OP_POP, '0, '0);
		issue(OP_GET, '0, '0);
		issue(OP_REMOVE, '0, '0);
		issue(OP_SET, '0, WORD_MAX);
		issue(OP_INSERT, 7'd1, WORD_MAX);
		// Build a short list with the extreme words, then get, set, find, remove and pop on it.
		issue(OP_INSERT, '0, WORD_MIN);
		issue(OP_PUSH, POS_TOP, WORD_MAX);
		issue(OP_PUSH, '0, WORD_ONES);
		issue(OP_PUSH, '0, '0);
		issue(OP_INSERT, 7'd4, 32'sd5);
		issue(OP_INSERT, 7'd1, 32'sd77);
		issue(OP_GET, '0, '0);
		issue(OP_GET, 7'd5, '0);
		issue(OP_SET, 7'd2, 32'sd123);
		issue(OP_FIND, '0, WORD_ONES);
		issue(OP_FIND, '0, 32'sd999);
		issue(OP_REMOVE, '0, '0);
		issue(OP_REMOVE, 7'd4, '0);
		issue(OP_GET, POS_TOP, WORD_ONES);
		issue(OP_POP, '0, '0);
		// Clear, then confirm the array reads as empty.
		issue(OP_CLEAR, POS_TOP, WORD_ONES);
		issue(OP_POP, '0, '0);
		issue(OP_GET, '0, '0);
		issue(OP_PUSH, '0, pick_data());
		drain();

		// Fill to capacity, then hit the full-array cases.
		repeat (DEPTH - 1)
			issue(OP_PUSH, pick_position(), pick_data());
		issue(OP_PUSH, '0, pick_data());
		issue(OP_INSERT, 7'(DEPTH + 1), pick_data());
		issue(OP_INSERT, 7'(DEPTH), pick_data());
		issue(OP_INSERT, '0, pick_data());
		issue(OP_GET, 7'(DEPTH - 1), '0);
		issue(OP_SET, 7'(DEPTH - 1), WORD_MIN);
		issue(OP_FIND, '0, WORD_MIN);
		issue(OP_REMOVE, '0, '0);
		issue(OP_REMOVE, 7'(DEPTH - 1), '0);
		issue(OP_PUSH, '0, pick_data());
		drain();

		// Random phases; every fourth runs with no gaps or stalls on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			mix = phase_mix_t'(ph % 3);
			steady_flow <= (ph % 4 == 3);
			repeat (PHASE_LEN)
				issue(pick_op(mix), pick_position(), pick_data());
			drain();
		end
		steady_flow <= 1'b0;

		// Allow for a stray response after the last expected one.
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && open_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/iate_pkg.sv
hdl/iate_if.sv
hdl/iate_cell.sv
hdl/indexed_array_table_engine.sv
dv/indexed_array_table_engine_checker.sv
dv/indexed_array_table_engine_tb.sv
